// ----- rtl/bmtlp_pkg.sv -----
`timescale 1ns / 1ps

package bmtlp_pkg;

    // Line buffer capacity; the line is dropped once it holds LINE_CAPACITY - 2 characters.
    localparam int LINE_CAPACITY = 128;
    localparam int LEN_W = 8;
    localparam logic [LEN_W-1:0] LINE_CLEAR_LEN = LEN_W'(LINE_CAPACITY - 2);

    localparam int VALUE_W = 32;

    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_V     = 8'h56;
    localparam logic [7:0] CHAR_I     = 8'h49;
    localparam logic [7:0] CHAR_S     = 8'h53;
    localparam logic [7:0] CHAR_O     = 8'h4F;
    localparam logic [7:0] CHAR_C     = 8'h43;

    typedef enum logic [1:0] {
        QTY_VOLTAGE = 2'd0,
        QTY_CURRENT = 2'd1,
        QTY_SOC     = 2'd2,
        QTY_UNKNOWN = 2'd3
    } quantity_t;

    typedef struct packed {
        logic                      valid;
        quantity_t                 quantity;
        logic signed [VALUE_W-1:0] value;
    } report_t;

endpackage

// ----- rtl/bmtlp_line_state.sv -----
`timescale 1ns / 1ps

module bmtlp_line_state (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    input  logic [7:0]          rx_byte,
    output bmtlp_pkg::report_t  report
);

    typedef enum logic [1:0] {
        PH_LABEL  = 2'd0,
        PH_BLANKS = 2'd1,
        PH_VALUE  = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    localparam int MAG_W = bmtlp_pkg::VALUE_W;
    localparam logic [MAG_W-1:0] MAG_LIMIT = {1'b1, {(MAG_W-1){1'b0}}};
    localparam logic [MAG_W-1:0] POS_MAX   = {1'b0, {(MAG_W-1){1'b1}}};

    phase_t                          phase_reg, phase_next;
    logic [bmtlp_pkg::LEN_W-1:0]     length_reg, length_next;
    logic [2:0]                      cand_reg, cand_next;
    logic [2:0]                      label_len_reg, label_len_next;
    logic [MAG_W-1:0]                mag_reg, mag_next;
    logic                            neg_reg, neg_next;
    logic                            stopped_reg, stopped_next;

    logic                            is_blank;
    logic                            is_digit;
    logic                            is_sign;
    logic [MAG_W+2:0]                mag_times_ten;
    logic [MAG_W-1:0]                mag_digit;
    logic [2:0]                      label_keep;
    logic [bmtlp_pkg::LEN_W-1:0]     length_inc;

    assign is_blank = (rx_byte == bmtlp_pkg::CHAR_SPACE) || (rx_byte == bmtlp_pkg::CHAR_TAB);
    assign is_digit = (rx_byte >= bmtlp_pkg::CHAR_ZERO) && (rx_byte <= bmtlp_pkg::CHAR_NINE);
    assign is_sign  = (rx_byte == bmtlp_pkg::CHAR_PLUS) || (rx_byte == bmtlp_pkg::CHAR_MINUS);

    // mag * 10 + digit as (mag << 3) + (mag << 1), then saturate at 2^31.
    assign mag_times_ten = {mag_reg, 3'b000} + {2'b00, mag_reg, 1'b0}
                         + (MAG_W+3)'(rx_byte - bmtlp_pkg::CHAR_ZERO);
    assign mag_digit = (mag_times_ten > (MAG_W+3)'(MAG_LIMIT)) ? MAG_LIMIT
                                                              : mag_times_ten[MAG_W-1:0];

    always_comb
    begin
        label_keep = 3'b000;
        case (label_len_reg)
            3'd0:
            begin
                label_keep[0] = (rx_byte == bmtlp_pkg::CHAR_V);
                label_keep[1] = (rx_byte == bmtlp_pkg::CHAR_I);
                label_keep[2] = (rx_byte == bmtlp_pkg::CHAR_S);
            end
            3'd1:    label_keep[2] = (rx_byte == bmtlp_pkg::CHAR_O);
            3'd2:    label_keep[2] = (rx_byte == bmtlp_pkg::CHAR_C);
            default: label_keep = 3'b000;
        endcase
    end

    assign length_inc = length_reg + 1'b1;

    always_comb
    begin
        phase_next     = phase_reg;
        length_next    = length_reg;
        cand_next      = cand_reg;
        label_len_next = label_len_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        stopped_next   = stopped_reg;

        if (byte_valid && rx_byte != bmtlp_pkg::CHAR_CR)
        begin
            if (rx_byte == bmtlp_pkg::CHAR_LF)
            begin
                phase_next     = PH_LABEL;
                length_next    = '0;
                cand_next      = 3'b111;
                label_len_next = '0;
                mag_next       = '0;
                neg_next       = 1'b0;
                stopped_next   = 1'b0;
            end
            else
            begin
                case (phase_reg)
                    PH_LABEL:
                    begin
                        if (is_blank)
                        begin
                            phase_next = PH_BLANKS;
                        end
                        else
                        begin
                            cand_next = cand_reg & label_keep;
                            if (label_len_reg < 3'd4)
                            begin
                                label_len_next = label_len_reg + 1'b1;
                            end
                        end
                    end
                    PH_BLANKS:
                    begin
                        if (!is_blank)
                        begin
                            phase_next = PH_VALUE;
                            // The first value character may carry the sign.
                            if (!stopped_reg)
                            begin
                                if (is_sign)
                                begin
                                    neg_next = (rx_byte == bmtlp_pkg::CHAR_MINUS);
                                end
                                else if (is_digit)
                                begin
                                    mag_next = mag_digit;
                                end
                                else
                                begin
                                    stopped_next = 1'b1;
                                end
                            end
                        end
                    end
                    PH_VALUE:
                    begin
                        if (is_blank)
                        begin
                            phase_next = PH_DONE;
                        end
                        else if (!stopped_reg)
                        begin
                            if (is_digit)
                            begin
                                mag_next = mag_digit;
                            end
                            else
                            begin
                                stopped_next = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase

                length_next = length_inc;
                if (length_inc >= bmtlp_pkg::LINE_CLEAR_LEN)
                begin
                    phase_next     = PH_LABEL;
                    length_next    = '0;
                    cand_next      = 3'b111;
                    label_len_next = '0;
                    mag_next       = '0;
                    neg_next       = 1'b0;
                    stopped_next   = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LABEL;
            length_reg    <= '0;
            cand_reg      <= 3'b111;
            label_len_reg <= '0;
            mag_reg       <= '0;
            neg_reg       <= 1'b0;
            stopped_reg   <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            length_reg    <= length_next;
            cand_reg      <= cand_next;
            label_len_reg <= label_len_next;
            mag_reg       <= mag_next;
            neg_reg       <= neg_next;
            stopped_reg   <= stopped_next;
        end
    end

    // The report reflects the line as it stands before the carriage return.
    always_comb
    begin
        report.valid = byte_valid && (rx_byte == bmtlp_pkg::CHAR_CR) && (length_reg != '0);

        if (label_len_reg == 3'd1 && cand_reg[0])
        begin
            report.quantity = bmtlp_pkg::QTY_VOLTAGE;
        end
        else if (label_len_reg == 3'd1 && cand_reg[1])
        begin
            report.quantity = bmtlp_pkg::QTY_CURRENT;
        end
        else if (label_len_reg == 3'd3 && cand_reg[2])
        begin
            report.quantity = bmtlp_pkg::QTY_SOC;
        end
        else
        begin
            report.quantity = bmtlp_pkg::QTY_UNKNOWN;
        end

        if (neg_reg)
        begin
            report.value = $signed(MAG_W'(0) - mag_reg);
        end
        else if (mag_reg > POS_MAX)
        begin
            report.value = $signed(POS_MAX);
        end
        else
        begin
            report.value = $signed(mag_reg);
        end
    end

endmodule

// ----- rtl/battery_monitor_text_line_parser_top.sv -----
`timescale 1ns / 1ps

// Text-line parser for a battery monitor's serial stream.
// The slave channel takes one received character per word in s_axis_tdata[7:0].
// Characters are parsed on the fly: a label, blanks, then a signed decimal value.
// A line feed clears the line; a carriage return on a non-empty line produces
// one word on the master channel: m_axis_tuser holds the quantity (voltage,
// current, state of charge, unrecognized) and m_axis_tdata the raw signed value
// in millivolts, milliamps or per-mille, with fractions dropped and overflow
// saturated. Any other byte produces no word.
// m_axis_tvalid is registered and rises in the cycle after the accepted carriage return.
// One character is taken every cycle while s_axis_tready is high; the line state updates
// combinationally from each character, bounded by the multiply-by-ten accumulate of the value.
// A finished result sits in the output register; the next character is still
// taken in the same cycle that the result is handed over, and s_axis_tready
// falls only while a result waits and m_axis_tready is low.
// Reset clears the line state and drops any pending result.
module battery_monitor_text_line_parser_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] reading_value
    output logic [1:0]  m_axis_tuser    // [1:0] quantity
);

    bmtlp_pkg::report_t report;
    logic               in_fire;

    logic                                 out_valid_reg, out_valid_next;
    bmtlp_pkg::quantity_t                 quantity_reg;
    logic signed [bmtlp_pkg::VALUE_W-1:0] value_reg;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    bmtlp_line_state u_line_state (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (in_fire),
        .rx_byte    (s_axis_tdata),
        .report     (report)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_fire)
        begin
            out_valid_next = report.valid;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && report.valid)
        begin
            quantity_reg <= report.quantity;
            value_reg    <= report.value;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = value_reg;
    assign m_axis_tuser  = quantity_reg;

endmodule

// ----- tb/battery_monitor_text_line_parser_top_tb.sv -----
`timescale 1ns / 1ps

module battery_monitor_text_line_parser_top_tb;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_BYTES = 570;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;

    // Bit positions in the set of labels that still match.
    localparam int CAND_V   = 0;
    localparam int CAND_I   = 1;
    localparam int CAND_SOC = 2;

    localparam logic [63:0] MAG_LIMIT = 64'h8000_0000;

    typedef enum logic [1:0] {
        LINE_LABEL,
        LINE_BLANKS,
        LINE_VALUE,
        LINE_DONE
    } line_phase_t;

    typedef struct {
        bmtlp_pkg::quantity_t quantity;
        logic signed [31:0]   value;
    } reading_t;

    class reading_scoreboard;
        line_phase_t                 phase;
        logic [bmtlp_pkg::LEN_W-1:0] line_len;
        logic [2:0]                  candidates;
        logic [2:0]                  label_len;
        logic [31:0]                 magnitude;
        logic                        negative;
        logic                        stopped;
        reading_t                    expected_readings[$];
        int                          mismatches;

        function new();
            clear_line();
            mismatches = 0;
        endfunction

        function void clear_line();
            phase      = LINE_LABEL;
            line_len   = '0;
            candidates = 3'b111;
            label_len  = '0;
            magnitude  = '0;
            negative   = 1'b0;
            stopped    = 1'b0;
        endfunction

        // Advances the line state by one accepted character and queues the
        // reading that a carriage return reports.
        function void note_byte(logic [7:0] c);
            reading_t    r;
            logic [2:0]  keep;
            logic [63:0] acc;
            logic        blank;
            logic        take_value;
            logic        first;
            blank      = (c == bmtlp_pkg::CHAR_SPACE) || (c == bmtlp_pkg::CHAR_TAB);
            take_value = 1'b0;
            first      = 1'b0;
            if (c == bmtlp_pkg::CHAR_CR)
            begin
                if (line_len != 0)
                begin
                    if (label_len == 1 && candidates[CAND_V])
                        r.quantity = bmtlp_pkg::QTY_VOLTAGE;
                    else if (label_len == 1 && candidates[CAND_I])
                        r.quantity = bmtlp_pkg::QTY_CURRENT;
                    else if (label_len == 3 && candidates[CAND_SOC])
                        r.quantity = bmtlp_pkg::QTY_SOC;
                    else
                        r.quantity = bmtlp_pkg::QTY_UNKNOWN;
                    if (negative)
                        r.value = 32'd0 - magnitude;
                    else if (magnitude > 32'h7FFF_FFFF)
                        r.value = 32'h7FFF_FFFF;
                    else
                        r.value = magnitude;
                    expected_readings.push_back(r);
                end
                return;
            end
            if (c == bmtlp_pkg::CHAR_LF)
            begin
                clear_line();
                return;
            end
            case (phase)
                LINE_LABEL:
                begin
                    if (blank)
                        phase = LINE_BLANKS;
                    else
                    begin
                        keep = 3'b000;
                        if (label_len == 0)
                        begin
                            keep[CAND_V]   = (c == bmtlp_pkg::CHAR_V);
                            keep[CAND_I]   = (c == bmtlp_pkg::CHAR_I);
                            keep[CAND_SOC] = (c == bmtlp_pkg::CHAR_S);
                        end
                        else if (label_len == 1)
                            keep[CAND_SOC] = (c == bmtlp_pkg::CHAR_O);
                        else if (label_len == 2)
                            keep[CAND_SOC] = (c == bmtlp_pkg::CHAR_C);
                        candidates = candidates & keep;
                        if (label_len < 3'd4)
                            label_len = label_len + 3'd1;
                    end
                end
                LINE_BLANKS:
                begin
                    if (!blank)
                    begin
                        phase      = LINE_VALUE;
                        take_value = 1'b1;
                        first      = 1'b1;
                    end
                end
                LINE_VALUE:
                begin
                    if (blank)
                        phase = LINE_DONE;
                    else
                        take_value = 1'b1;
                end
                default:
                begin
                end
            endcase
            if (take_value && !stopped)
            begin
                if (first && (c == bmtlp_pkg::CHAR_PLUS || c == bmtlp_pkg::CHAR_MINUS))
                    negative = (c == bmtlp_pkg::CHAR_MINUS);
                else if (c >= bmtlp_pkg::CHAR_ZERO && c <= bmtlp_pkg::CHAR_NINE)
                begin
                    acc = 64'(magnitude) * 64'd10 + 64'(c - bmtlp_pkg::CHAR_ZERO);
                    magnitude = (acc > MAG_LIMIT) ? MAG_LIMIT[31:0] : acc[31:0];
                end
                else
                    stopped = 1'b1;
            end
            line_len = line_len + 1'b1;
            if (line_len >= bmtlp_pkg::LINE_CLEAR_LEN)
                clear_line();
        endfunction

        function void check_reading(logic [1:0] qty, logic [31:0] value);
            reading_t r;
            if (expected_readings.size() == 0)
            begin
                $error("unexpected reading: quantity %0d reading_value %0d",
                       qty, $signed(value));
                mismatches++;
                return;
            end
            r = expected_readings.pop_front();
            if (qty !== r.quantity)
            begin
                $error("quantity: expected %0d actual %0d", r.quantity, qty);
                mismatches++;
            end
            if (value !== r.value)
            begin
                $error("reading_value: expected %0d actual %0d",
                       r.value, $signed(value));
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction
    endclass

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [7:0]  s_axis_tdata  = 8'd0;
    logic        m_axis_tready = 1'b0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    reading_scoreboard readings = new();

    int cycles     = 0;
    int bytes_sent = 0;
    int burst_left = 0;
    int stall_mode = 0;
    int mode_left  = 0;
    int stall_tick = 0;

    battery_monitor_text_line_parser_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Result side: check accepted words, then pick the next ready value from
    // a stall mode that is chosen at random and changed from time to time.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            readings.check_reading(m_axis_tuser, m_axis_tdata);
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(10, 80);
        end
        else
            mode_left--;
        stall_tick++;
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 99) < 70);
            2:       m_axis_tready <= (stall_tick % 5 == 0);
            default: m_axis_tready <= ($urandom_range(0, 99) < 15);
        endcase
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        readings.note_byte(b);
        bytes_sent++;
        burst_left--;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (readings.pending() > 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] printable();
        return 8'($urandom_range(33, 126));
    endfunction

    function automatic logic [7:0] blank_char();
        return ($urandom_range(0, 1) == 0) ? bmtlp_pkg::CHAR_SPACE : bmtlp_pkg::CHAR_TAB;
    endfunction

    // Mostly well-formed lines with random content; the rest is raw noise,
    // overlong lines, stray line feeds and lines left unterminated.
    task automatic random_line();
        int    kind;
        int    n;
        string labels[7];
        labels = '{"V", "I", "SOC", "SO", "SOCX", "VI", "S"};
        kind = $urandom_range(0, 99);
        if (kind < 8)
        begin
            n = $urandom_range(1, 12);
            repeat (n) send_byte(8'($urandom_range(0, 255)));
        end
        else if (kind < 10)
        begin
            n = $urandom_range(120, 130);
            repeat (n) send_byte(printable());
            send_byte(bmtlp_pkg::CHAR_CR);
            send_byte(bmtlp_pkg::CHAR_LF);
        end
        else
        begin
            kind = $urandom_range(0, 99);
            if (kind < 75)
                send_text(labels[$urandom_range(0, 2)]);
            else if (kind < 85)
                send_text(labels[$urandom_range(3, 6)]);
            else if (kind < 95)
            begin
                n = $urandom_range(1, 5);
                repeat (n) send_byte(printable());
            end
            n = $urandom_range(1, 3);
            repeat (n) send_byte(blank_char());
            kind = $urandom_range(0, 99);
            if (kind < 15)
                send_byte(bmtlp_pkg::CHAR_MINUS);
            else if (kind < 25)
                send_byte(bmtlp_pkg::CHAR_PLUS);
            n = ($urandom_range(0, 99) < 10) ? $urandom_range(10, 12) : $urandom_range(0, 6);
            repeat (n) send_byte(bmtlp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
            if ($urandom_range(0, 99) < 15)
            begin
                send_byte(8'h2E);
                n = $urandom_range(1, 3);
                repeat (n) send_byte(bmtlp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
            end
            if ($urandom_range(0, 99) < 10)
            begin
                send_byte(blank_char());
                send_byte(printable());
            end
            if ($urandom_range(0, 99) < 5)
                send_byte(bmtlp_pkg::CHAR_LF);
            send_byte(bmtlp_pkg::CHAR_CR);
            if ($urandom_range(0, 99) < 10)
                send_byte(bmtlp_pkg::CHAR_CR);
            if ($urandom_range(0, 99) < 85)
                send_byte(bmtlp_pkg::CHAR_LF);
        end
    endtask

    initial
    begin
        int  random_start;
        bit  paused;
        paused = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("V\t12800\r\n");
        send_text("I -1234\r\n");
        send_text("SOC 955\r\n");
        send_text("SOC\t +0\r");
        // A second carriage return reports the same line again.
        send_text("\r\n");
        send_text("\r");
        send_text(" 12\r\n");
        send_text("VV 5\r\n");
        send_text("V 12.75\r\n");
        send_text("V 3 9\r\n");
        send_text("I 2147483647\r\n");
        send_text("I 99999999999\r\n");
        send_text("I -2147483648\r\n");
        send_text("I -99999999999\r\n");
        send_text("V -\r\n");
        send_text("V +-5\r\n");
        send_text("SOCK 1\r\n");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text(" 7\r\n");
        // Filling the line clears it, so the carriage return finds it empty.
        repeat (int'(bmtlp_pkg::LINE_CLEAR_LEN)) send_byte(8'h78);
        send_text("\rV 5\r\n");
        wait_drained();

        random_start = bytes_sent;
        while (bytes_sent - random_start < RANDOM_BYTES)
        begin
            random_line();
            if (!paused && bytes_sent - random_start > RANDOM_BYTES / 2)
            begin
                wait_drained();
                paused = 1'b1;
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (readings.mismatches == 0 && readings.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
